>>> sv/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants for the circle-circle resolve pipeline.
// ----------------------------------------------------------------------------
package ccr_pkg;

    localparam int SQRT_STEPS = 32;  // one root bit per stage
    localparam int DIV_STEPS  = 32;  // one quotient bit per stage

    localparam logic [31:0] Q_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_NEG_MAX = 32'h8000_0000;

    // Geometry carried alongside the square root
    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] r;
        logic        neg_x;
        logic        neg_y;
        logic        touch;
        logic        ovl;
        logic        coin;
    } t_geo;

    // Flags carried alongside the divider
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic touch;
        logic ovl;
        logic coin;
    } t_flags;

endpackage

>>> sv/ccr_if.sv
// ----------------------------------------------------------------------------
// ccr_in_if / ccr_out_if
// Valid/ready channels for circle pairs and their resolve results.
// ----------------------------------------------------------------------------
interface ccr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic        [30:0] first_radius;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic        [30:0] second_radius;

    modport source (output valid, first_x, first_y, first_radius,
                    second_x, second_y, second_radius, input ready);
    modport sink   (input valid, first_x, first_y, first_radius,
                    second_x, second_y, second_radius, output ready);
endinterface

interface ccr_out_if;
    logic               valid;
    logic               ready;
    logic               touching;
    logic               overlapping;
    logic signed [31:0] push_x;
    logic signed [31:0] push_y;
    logic               centres_coincide;
    logic               push_saturated;

    modport source (output valid, touching, overlapping, push_x, push_y,
                    centres_coincide, push_saturated, input ready);
    modport sink   (input valid, touching, overlapping, push_x, push_y,
                    centres_coincide, push_saturated, output ready);
endinterface

>>> sv/ccr_sqrt.sv
// ----------------------------------------------------------------------------
// ccr_sqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module ccr_sqrt
    import ccr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_n,
    input  t_geo        i_side,
    output logic        o_valid,
    output logic [31:0] o_root,
    output t_geo        o_side
);

    logic        r_v    [0:SQRT_STEPS];
    logic [34:0] r_rem  [0:SQRT_STEPS];
    logic [31:0] r_root [0:SQRT_STEPS];
    logic [63:0] r_n    [0:SQRT_STEPS];
    t_geo        r_side [0:SQRT_STEPS];

    // entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_n[0]    <= i_n;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_step
        logic [34:0] rem_sh;
        logic [34:0] trial;
        logic        take;

        always_comb begin
            rem_sh = {r_rem[k-1][32:0], r_n[k-1][63:62]};
            trial  = {1'b0, r_root[k-1], 2'b01};
            take   = (rem_sh >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? (rem_sh - trial) : rem_sh;
                r_root[k] <= {r_root[k-1][30:0], take};
                r_n[k]    <= {r_n[k-1][61:0], 2'b00};
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[SQRT_STEPS];
    assign o_root  = r_root[SQRT_STEPS];
    assign o_side  = r_side[SQRT_STEPS];

endmodule

>>> sv/ccr_div.sv
// ----------------------------------------------------------------------------
// ccr_div
// Two-lane pipelined restoring divider, 64 / 32 bits, quotient below 2^32.
// ----------------------------------------------------------------------------
module ccr_div
    import ccr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [63:0] i_num_x,
    input  logic [63:0] i_num_y,
    input  logic [31:0] i_den,
    input  t_flags      i_side,
    output logic        o_valid,
    output logic [31:0] o_q_x,
    output logic [31:0] o_q_y,
    output t_flags      o_side
);

    logic        r_v     [0:DIV_STEPS];
    logic [31:0] r_rem_x [0:DIV_STEPS];
    logic [31:0] r_rem_y [0:DIV_STEPS];
    logic [31:0] r_lo_x  [0:DIV_STEPS];  // dividend bits in, quotient bits out
    logic [31:0] r_lo_y  [0:DIV_STEPS];
    logic [31:0] r_den   [0:DIV_STEPS];
    t_flags      r_side  [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    // upper half is below the divisor whenever the quotient fits 32 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem_x[0] <= i_num_x[63:32];
            r_rem_y[0] <= i_num_y[63:32];
            r_lo_x[0]  <= i_num_x[31:0];
            r_lo_y[0]  <= i_num_y[31:0];
            r_den[0]   <= i_den;
            r_side[0]  <= i_side;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [32:0] sh_x;
        logic [32:0] sh_y;
        logic        tk_x;
        logic        tk_y;
        logic [32:0] df_x;
        logic [32:0] df_y;

        always_comb begin
            sh_x = {r_rem_x[k-1], r_lo_x[k-1][31]};
            sh_y = {r_rem_y[k-1], r_lo_y[k-1][31]};
            df_x = sh_x - {1'b0, r_den[k-1]};
            df_y = sh_y - {1'b0, r_den[k-1]};
            tk_x = (sh_x >= {1'b0, r_den[k-1]});
            tk_y = (sh_y >= {1'b0, r_den[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_x[k] <= tk_x ? df_x[31:0] : sh_x[31:0];
                r_rem_y[k] <= tk_y ? df_y[31:0] : sh_y[31:0];
                r_lo_x[k]  <= {r_lo_x[k-1][30:0], tk_x};
                r_lo_y[k]  <= {r_lo_y[k-1][30:0], tk_y};
                r_den[k]   <= r_den[k-1];
                r_side[k]  <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS];
    assign o_q_x   = r_lo_x[DIV_STEPS];
    assign o_q_y   = r_lo_y[DIV_STEPS];
    assign o_side  = r_side[DIV_STEPS];

endmodule

>>> sv/circle_circle_resolve_top.sv
// ----------------------------------------------------------------------------
// circle_circle_resolve_top
// Touch/overlap test and separating push for a pair of fixed-point circles.
// ----------------------------------------------------------------------------
// Path: an accepted transaction passes stages A to D, the square root, stages E and F,
//   the divider and the output register to o_out. Throughput: one transaction per cycle;
//   the whole pipe moves together whenever the output register is empty or being taken.
// The 32-stage square root and 32-stage divider set the latency.
// Reset (i_rst_n low, synchronous) clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
module circle_circle_resolve_top
    import ccr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccr_in_if.sink     i_in,
    ccr_out_if.source  o_out
);

    // Global advance: every stage moves when the output slot frees up.
    logic r_ov;
    logic adv;
    assign adv        = !r_ov || o_out.ready;
    assign i_in.ready = adv;

    // ---- stage A: input register ----
    logic               r_a_v;
    logic signed [31:0] r_a_x1, r_a_y1, r_a_x2, r_a_y2;
    logic        [30:0] r_a_r1, r_a_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_x1 <= i_in.first_x;
            r_a_y1 <= i_in.first_y;
            r_a_r1 <= i_in.first_radius;
            r_a_x2 <= i_in.second_x;
            r_a_y2 <= i_in.second_y;
            r_a_r2 <= i_in.second_radius;
        end
    end

    // ---- stage B: differences, magnitudes, radius sum ----
    logic signed [32:0] dx, dy;
    logic        [32:0] n_ax, n_ay;
    always_comb begin
        dx   = {r_a_x1[31], r_a_x1} - {r_a_x2[31], r_a_x2};
        dy   = {r_a_y1[31], r_a_y1} - {r_a_y2[31], r_a_y2};
        n_ax = dx[32] ? 33'(-dx) : 33'(dx);
        n_ay = dy[32] ? 33'(-dy) : 33'(dy);
    end

    logic        r_b_v;
    logic [32:0] r_b_ax, r_b_ay;
    logic [31:0] r_b_r;
    logic        r_b_nx, r_b_ny, r_b_coin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (adv) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_ax   <= n_ax;
            r_b_ay   <= n_ay;
            r_b_r    <= {1'b0, r_a_r1} + {1'b0, r_a_r2};
            r_b_nx   <= dx[32];
            r_b_ny   <= dy[32];
            r_b_coin <= (dx == '0) && (dy == '0);
        end
    end

    // ---- stage C: squares (a magnitude of 2^32 squares to 2^64) ----
    logic        r_c_v;
    logic [64:0] r_c_sx, r_c_sy;
    logic [63:0] r_c_r2;
    logic [31:0] r_c_ax, r_c_ay, r_c_r;
    logic        r_c_nx, r_c_ny, r_c_coin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (adv) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_sx   <= r_b_ax[32] ? {1'b1, 64'd0}
                                   : {1'b0, 64'(r_b_ax[31:0]) * 64'(r_b_ax[31:0])};
            r_c_sy   <= r_b_ay[32] ? {1'b1, 64'd0}
                                   : {1'b0, 64'(r_b_ay[31:0]) * 64'(r_b_ay[31:0])};
            r_c_r2   <= 64'(r_b_r) * 64'(r_b_r);
            r_c_ax   <= r_b_ax[31:0];
            r_c_ay   <= r_b_ay[31:0];
            r_c_r    <= r_b_r;
            r_c_nx   <= r_b_nx;
            r_c_ny   <= r_b_ny;
            r_c_coin <= r_b_coin;
        end
    end

    // ---- stage D: squared distance and compare against squared sum ----
    logic [65:0] d2;
    logic        d2_big;
    assign d2     = {1'b0, r_c_sx} + {1'b0, r_c_sy};
    assign d2_big = (d2[65:64] != 2'b00);

    logic        r_d_v;
    logic [63:0] r_d_d2;
    t_geo        r_d_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (adv) begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_d2        <= d2[63:0];
            r_d_geo.ax    <= r_c_ax;
            r_d_geo.ay    <= r_c_ay;
            r_d_geo.r     <= r_c_r;
            r_d_geo.neg_x <= r_c_nx;
            r_d_geo.neg_y <= r_c_ny;
            r_d_geo.touch <= !d2_big && (d2[63:0] <= r_c_r2);
            r_d_geo.ovl   <= !d2_big && (d2[63:0] <  r_c_r2);
            r_d_geo.coin  <= r_c_coin;
        end
    end

    // ---- distance: floor square root ----
    logic        s_v;
    logic [31:0] s_root;
    t_geo        s_geo;

    ccr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_d_v),
        .i_n     (r_d_d2),
        .i_side  (r_d_geo),
        .o_valid (s_v),
        .o_root  (s_root),
        .o_side  (s_geo)
    );

    // ---- stage E: penetration depth m = r - d ----
    logic        r_e_v;
    logic [31:0] r_e_m, r_e_d;
    t_geo        r_e_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (adv) begin
            r_e_v <= s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_m   <= s_geo.r - s_root;
            r_e_d   <= s_root;
            r_e_geo <= s_geo;
        end
    end

    // ---- stage F: numerators |dx|*m, |dy|*m (|dx| <= d when overlapping) ----
    logic        r_f_v;
    logic [63:0] r_f_nx, r_f_ny;
    logic [31:0] r_f_d;
    t_flags      r_f_fl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (adv) begin
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f_nx       <= 64'(r_e_geo.ax) * 64'(r_e_m);
            r_f_ny       <= 64'(r_e_geo.ay) * 64'(r_e_m);
            r_f_d        <= r_e_d;
            r_f_fl.neg_x <= r_e_geo.neg_x;
            r_f_fl.neg_y <= r_e_geo.neg_y;
            r_f_fl.touch <= r_e_geo.touch;
            r_f_fl.ovl   <= r_e_geo.ovl;
            r_f_fl.coin  <= r_e_geo.coin;
        end
    end

    // ---- divide by distance ----
    logic        q_v;
    logic [31:0] q_x, q_y;
    t_flags      q_fl;

    ccr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_f_v),
        .i_num_x (r_f_nx),
        .i_num_y (r_f_ny),
        .i_den   (r_f_d),
        .i_side  (r_f_fl),
        .o_valid (q_v),
        .o_q_x   (q_x),
        .o_q_y   (q_y),
        .o_side  (q_fl)
    );

    // ---- output: sign, clamp, zero when no push applies ----
    logic        push_on;
    logic        sat_x, sat_y;
    logic [31:0] px, py;

    always_comb begin
        push_on = q_fl.ovl && !q_fl.coin;
        if (q_fl.neg_x) begin
            sat_x = (q_x > Q_NEG_MAX);
            px    = sat_x ? Q_NEG_MAX : (32'd0 - q_x);
        end else begin
            sat_x = (q_x > Q_POS_MAX);
            px    = sat_x ? Q_POS_MAX : q_x;
        end
        if (q_fl.neg_y) begin
            sat_y = (q_y > Q_NEG_MAX);
            py    = sat_y ? Q_NEG_MAX : (32'd0 - q_y);
        end else begin
            sat_y = (q_y > Q_POS_MAX);
            py    = sat_y ? Q_POS_MAX : q_y;
        end
    end

    logic        r_o_touch, r_o_ovl, r_o_coin, r_o_sat;
    logic [31:0] r_o_px, r_o_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_touch <= q_fl.touch;
            r_o_ovl   <= q_fl.ovl;
            r_o_coin  <= q_fl.coin;
            r_o_sat   <= push_on && (sat_x || sat_y);
            r_o_px    <= push_on ? px : 32'd0;
            r_o_py    <= push_on ? py : 32'd0;
        end
    end

    assign o_out.valid            = r_ov;
    assign o_out.touching         = r_o_touch;
    assign o_out.overlapping      = r_o_ovl;
    assign o_out.push_x           = r_o_px;
    assign o_out.push_y           = r_o_py;
    assign o_out.centres_coincide = r_o_coin;
    assign o_out.push_saturated   = r_o_sat;

endmodule
